[src/sst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants, codes and controller/datapath interface types for the
// small set table.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Table geometry
    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Field widths on the ports
    localparam int KIND_W      = 2;
    localparam int VALUE_IN_W  = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_W     = 6;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 8;
    localparam int M_TUSER_W   = 3;

    // Operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PRESENT_ALREADY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL            = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND       = 3'd4;
    localparam logic [STATUS_W-1:0] ST_PRESENT         = 3'd5;
    localparam logic [STATUS_W-1:0] ST_ABSENT          = 3'd6;

    // Controller -> datapath
    typedef struct packed {
        logic load;     // latch item, restart search
        logic search;   // issue next read, compare previous one
        logic move_rd;  // read last filled entry
        logic commit;   // apply update, load output register
    } sst_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic hit;        // compared entry matches
        logic miss_done;  // search exhausted without a match
        logic is_erase;   // current item is an erase
        logic out_free;   // output register can take a result
    } sst_stat_t;

endpackage

[src/sst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: accept, search, optional move read for erase, commit.
// ----------------------------------------------------------------------------
module sst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sst_pkg::sst_stat_t stat,
    output sst_pkg::sst_cmd_t  cmd
);
    import sst_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_MOVE   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                if (stat.hit) begin
                    state_next = stat.is_erase ? S_MOVE : S_FINISH;
                end else if (stat.miss_done) begin
                    state_next = S_FINISH;
                end
            end
            S_MOVE: begin
                cmd.move_rd = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[src/sst_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sst_datapath
// Entry memory, fill count, search pointer and compare stage, output register.
// ----------------------------------------------------------------------------
module sst_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sst_pkg::sst_cmd_t             cmd,
    output sst_pkg::sst_stat_t            stat,
    input  logic [sst_pkg::KIND_W-1:0]     in_kind,
    input  logic [sst_pkg::VALUE_IN_W-1:0] in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sst_pkg::STATUS_W-1:0]   out_status,
    output logic [sst_pkg::COUNT_W-1:0]    out_count
);
    import sst_pkg::*;

    // Entry store, one read and one write port
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];

    logic [KIND_W-1:0]      kind_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]       fill_reg;
    logic [CNT_W-1:0]       fill_next;
    logic [CNT_W-1:0]       idx_reg;
    logic [ADDR_W-1:0]      cmp_idx_reg;
    logic                   cmp_valid_reg;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   found_reg;
    logic [ADDR_W-1:0]      slot_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [COUNT_W-1:0]     out_count_reg;

    logic                   more;
    logic                   hit;
    logic [CNT_W-1:0]       last_idx;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [STATUS_W-1:0]    status_next;

    assign more     = (idx_reg < fill_reg);
    assign hit      = cmp_valid_reg && (rd_data_reg == value_reg);
    assign last_idx = fill_reg - CNT_W'(1);

    assign stat.hit       = hit;
    assign stat.miss_done = !hit && !more;
    assign stat.is_erase  = (kind_reg == KIND_ERASE);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Read port: search pointer, or last entry for an erase
    assign rd_en   = (cmd.search && more) || cmd.move_rd;
    assign rd_addr = cmd.move_rd ? last_idx[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    // Update decision at commit
    always_comb begin
        fill_next   = fill_reg;
        status_next = ST_ABSENT;
        wr_en       = 1'b0;
        wr_addr     = fill_reg[ADDR_W-1:0];
        wr_data     = value_reg;
        case (kind_reg)
            KIND_INSERT: begin
                if (found_reg) begin
                    status_next = ST_PRESENT_ALREADY;
                end else if (fill_reg >= CNT_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    status_next = ST_INSERTED;
                    wr_en       = 1'b1;
                    fill_next   = fill_reg + CNT_W'(1);
                end
            end
            KIND_ERASE: begin
                if (found_reg) begin
                    // last entry fills the hole
                    status_next = ST_REMOVED;
                    wr_en       = 1'b1;
                    wr_addr     = slot_reg;
                    wr_data     = rd_data_reg;
                    fill_next   = last_idx;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default: begin
                status_next = found_reg ? ST_PRESENT : ST_ABSENT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= in_kind;
            value_reg <= VALUE_WIDTH'(in_value);
        end
        if (cmd.search) begin
            cmp_idx_reg <= idx_reg[ADDR_W-1:0];
        end
        if (cmd.search && hit) begin
            slot_reg <= cmp_idx_reg;
        end
        if (cmd.commit) begin
            out_status_reg <= status_next;
            out_count_reg  <= COUNT_W'(fill_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg       <= '0;
                cmp_valid_reg <= 1'b0;
                found_reg     <= 1'b0;
            end else if (cmd.search) begin
                cmp_valid_reg <= more;
                if (more) begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                if (hit) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

[src/small_set_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// small_set_table_top
// Set of distinct values held in a fixed table with a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer per operation. s_tuser carries the
//   operation (insert, erase, membership query), s_tdata the value.
//   Result stream (m_*): exactly one transfer per operation, m_tuser the
//   status code, m_tdata the number of values held afterwards.
//   Lookup is a linear search over the filled entries, one memory read per
//   cycle through a single read port, with a registered compare stage.
//   An erase that finds its value also reads the last entry to fill the
//   hole. An item occupies the block from acceptance to commit, so a new
//   item is accepted only after the previous one has been committed.
//   The result sits in an output register: the next item is accepted while
//   it waits; a stalled receiver only holds back the commit of that next item.
//   Reset (aresetn low, synchronous) empties the table; stored entries are
//   not cleared, they are only ever read below the fill count.
// ----------------------------------------------------------------------------
module small_set_table_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sst_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] value
    input  logic [sst_pkg::S_TUSER_W-1:0]   s_tuser,   // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sst_pkg::M_TDATA_W-1:0]   m_tdata,   // [5:0] count, [7:6] zero
    output logic [sst_pkg::M_TUSER_W-1:0]   m_tuser    // [2:0] status
);
    import sst_pkg::*;

    sst_cmd_t               cmd;
    sst_stat_t              stat;
    logic [COUNT_W-1:0]     count;

    // Sequencer
    sst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table storage, search and result register
    sst_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_tuser),
        .in_value   (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_count  (count)
    );

    // count padded to a whole byte
    assign m_tdata = M_TDATA_W'(count);

endmodule
